// ===== rtl/core/dqvc_pkg.sv =====
package dqvc_pkg;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_COUNT      = 3'd4;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] value;
  } dqvc_in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] match_count;
    logic [4:0] occupancy;
  } dqvc_out_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic scan;
    logic drain;
    logic publish;
  } dqvc_cmd_t;

  typedef struct packed {
    logic is_count;
    logic empty;
    logic scan_last;
  } dqvc_sts_t;

endpackage

// ===== rtl/core/dqvc_ctrl.sv =====
module dqvc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  dqvc_pkg::dqvc_sts_t  sts,
  output dqvc_pkg::dqvc_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_EXEC  = 2'd1;
  localparam logic [1:0] S_SCAN  = 2'd2;
  localparam logic [1:0] S_DRAIN = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.is_count && !sts.empty) begin
          state_nxt = S_SCAN;
        end else begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        cmd.drain   = 1'b1;
        cmd.publish = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ===== rtl/core/dqvc_dp.sv =====
module dqvc_dp #(
  parameter int DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dqvc_pkg::dqvc_in_t   in_item,
  input  dqvc_pkg::dqvc_cmd_t  cmd,
  output dqvc_pkg::dqvc_sts_t  sts,
  output logic                 out_strobe,
  output dqvc_pkg::dqvc_out_t  out_item
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);
  localparam logic [SW-1:0] WRAP      = SW'(DEPTH);

  logic [31:0] mem [DEPTH];

  logic [2:0]    op_r;
  logic [31:0]   value_r;
  logic [AW-1:0] front_r;
  logic [AW-1:0] front_nxt;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;
  logic [AW-1:0] ptr_r;
  logic [CW-1:0] k_r;
  logic [CW-1:0] matches_r;
  logic [CW-1:0] matches_nxt;
  logic [31:0]   rd_data_r;
  logic          cmp_v_r;
  logic          out_strobe_r;
  dqvc_pkg::dqvc_out_t out_r;

  logic          full;
  logic          empty;
  logic [AW-1:0] front_dec;
  logic [AW-1:0] ptr_inc;
  logic [SW-1:0] back_sum;
  logic [AW-1:0] back_slot;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [1:0]    status_c;
  logic          hit;

  assign full      = (count_r == FULL_CNT);
  assign empty     = (count_r == '0);
  assign front_dec = (front_r == '0) ? LAST_SLOT : front_r - 1'b1;
  assign ptr_inc   = (ptr_r == LAST_SLOT) ? '0 : ptr_r + 1'b1;
  assign back_sum  = SW'(front_r) + SW'(count_r);
  assign back_slot = (back_sum >= WRAP) ? AW'(back_sum - WRAP) : AW'(back_sum);
  assign hit       = cmp_v_r && (rd_data_r == value_r);
  assign matches_nxt = matches_r + CW'(hit);

  always_comb begin
    front_nxt = front_r;
    count_nxt = count_r;
    wr_en     = 1'b0;
    wr_addr   = back_slot;
    status_c  = dqvc_pkg::ST_DONE;
    unique case (op_r) inside
      dqvc_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          status_c = dqvc_pkg::ST_FULL;
        end else begin
          front_nxt = front_dec;
          count_nxt = count_r + 1'b1;
          wr_en     = 1'b1;
          wr_addr   = front_dec;
        end
      end
      dqvc_pkg::OP_PUSH_BACK: begin
        if (full) begin
          status_c = dqvc_pkg::ST_FULL;
        end else begin
          count_nxt = count_r + 1'b1;
          wr_en     = 1'b1;
        end
      end
      dqvc_pkg::OP_POP_FRONT, dqvc_pkg::OP_POP_BACK: begin
        if (empty) begin
          status_c = dqvc_pkg::ST_EMPTY;
        end else begin
          count_nxt = count_r - 1'b1;
          if (op_r == dqvc_pkg::OP_POP_FRONT) begin
            front_nxt = (front_r == LAST_SLOT) ? '0 : front_r + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign sts.is_count  = (op_r == dqvc_pkg::OP_COUNT);
  assign sts.empty     = empty;
  assign sts.scan_last = (k_r == count_r - 1'b1);

  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[wr_addr] <= value_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_data_r <= mem[ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_item.op;
      value_r <= in_item.value;
    end
    if (cmd.exec) begin
      ptr_r     <= front_r;
      k_r       <= '0;
      matches_r <= '0;
    end else begin
      matches_r <= matches_nxt;
      if (cmd.scan) begin
        ptr_r <= ptr_inc;
        k_r   <= k_r + 1'b1;
      end
    end
    if (cmd.publish) begin
      out_r.status      <= status_c;
      out_r.match_count <= cmd.drain ? 5'(matches_nxt) : 5'd0;
      out_r.occupancy   <= cmd.exec ? 5'(count_nxt) : 5'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r      <= '0;
      count_r      <= '0;
      cmp_v_r      <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      if (cmd.exec) begin
        front_r <= front_nxt;
        count_r <= count_nxt;
      end
      cmp_v_r      <= cmd.scan;
      out_strobe_r <= cmd.publish;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

endmodule

// ===== rtl/core/deque_with_value_count_unit.sv =====
// Channel   Ports                    Transfer
// input     start, busy, in_item     taken when start is high and busy is low
// result    out_strobe, out_item     strobed for a single cycle, cannot be held off
//
// Push, pop, unknown ops and a count on an empty queue: the item is latched on accept,
// executed in EXEC, and its result and strobe registered together.
// Count on n >= 1 held entries: EXEC, then SCAN over the entries, then DRAIN; the
// scan reads the entry store one slot per cycle through its single registered read port.
// Reset (rst_n low, synchronous) empties the queue; stored values are kept.
// busy drops in the cycle the result is strobed, so the next item may be
// taken alongside it.
module deque_with_value_count_unit #(
  parameter int DEPTH = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  dqvc_pkg::dqvc_in_t   in_item,
  output logic                 out_strobe,
  output dqvc_pkg::dqvc_out_t  out_item
);

  dqvc_pkg::dqvc_cmd_t cmd;
  dqvc_pkg::dqvc_sts_t sts;

  dqvc_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  dqvc_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cmd        (cmd),
    .sts        (sts),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

// ===== rtl/core/dqvc_chk.sv =====
module dqvc_chk (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 start,
  input logic                 busy,
  input logic                 out_strobe,
  input dqvc_pkg::dqvc_out_t  out_item
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("item accepted but block not busy");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for two cycles");

  a_result_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> (out_strobe && !busy))
    else $error("item finished without a result");

  a_refused_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.status != dqvc_pkg::ST_DONE) |->
      (out_item.match_count == 5'd0))
    else $error("refused item reports matches");

endmodule

bind deque_with_value_count_unit dqvc_chk u_dqvc_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);
